// ===== rtl/vertex_project_to_window_defines.svh =====
// Assertion helpers, included by vpw_front and vpw_back. Each one samples on the
// rising edge of clk and is disabled while rst_n is low.
`ifndef VERTEX_PROJECT_TO_WINDOW_DEFINES_SVH
`define VERTEX_PROJECT_TO_WINDOW_DEFINES_SVH

// Same-cycle implication.
`define VPW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VPW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vpw_pkg.sv =====
`timescale 1ns / 1ps
package vpw_pkg;

  // Function codes of an input word.
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_PROJECT = 1'b1;

  // Configuration register indexes.
  localparam logic [3:0] REG_VIEW_X      = 4'd0;
  localparam logic [3:0] REG_VIEW_Y      = 4'd1;
  localparam logic [3:0] REG_VIEW_WIDTH  = 4'd2;
  localparam logic [3:0] REG_VIEW_HEIGHT = 4'd3;

  // One input word as it sits in the front queue.
  typedef struct packed {
    logic               func;
    logic [3:0]         elem_index;
    logic signed [31:0] elem_value;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } item_t;

  // Viewport settings handed to the back end.
  typedef struct packed {
    logic signed [15:0] view_x;
    logic signed [15:0] view_y;
    logic [14:0]        view_width;
    logic [14:0]        view_height;
  } view_cfg_t;

  // Clamp a 64-bit signed value into the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/vpw_front.sv =====
`timescale 1ns / 1ps
`include "vertex_project_to_window_defines.svh"
module vpw_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  vpw_pkg::item_t push_item,
  input  logic           deq,
  output logic           empty,
  output vpw_pkg::item_t head_item
);
  import vpw_pkg::*;

  // Two-word queue between the input port and the back end.
  item_t      slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_deq;

  assign full      = (cnt_r == 2'd2);
  assign empty     = (cnt_r == 2'd0);
  assign head_item = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_deq    = deq && !empty;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_deq ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_deq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Words are stored as they arrive; the function code travels with them.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/vpw_back.sv =====
`timescale 1ns / 1ps
`include "vertex_project_to_window_defines.svh"
module vpw_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  vpw_pkg::item_t      q_item,
  output logic                q_deq,
  input  vpw_pkg::view_cfg_t  cfg,
  input  logic                out_pop,
  output logic                out_empty,
  output logic signed [31:0]  out_win_x,
  output logic signed [31:0]  out_win_y,
  output logic signed [31:0]  out_win_z,
  output logic                out_ok
);
  import vpw_pkg::*;

  localparam logic signed [31:0] ONE  = 32'(1) << FRAC_BITS;
  localparam logic signed [49:0] HALF = 50'(1) << (FRAC_BITS - 1);
  localparam logic [48:0]        CAP  = 49'(1) << 48;
  localparam logic signed [42:0] HLIM = 43'(1) << 41;
  localparam int                 DW   = 64 + FRAC_BITS;

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b0000000001,
    ST_MUL      = 10'b0000000010,
    ST_ACC      = 10'b0000000100,
    ST_DIV_INIT = 10'b0000001000,
    ST_DIV_RUN  = 10'b0000010000,
    ST_DIV_END  = 10'b0000100000,
    ST_SC_LO    = 10'b0001000000,
    ST_SC_HI    = 10'b0010000000,
    ST_SC_ACC   = 10'b0100000000,
    ST_DONE     = 10'b1000000000
  } state_t;

  state_t             state_r;
  logic signed [31:0] m_r [16];
  logic signed [31:0] vx_r, vy_r, vz_r;
  logic signed [63:0] p_r [4];
  logic signed [63:0] acc_r;
  logic signed [63:0] prod_r;
  logic [1:0]         row_r, col_r, d_r;
  logic [63:0]        rem_r, div_b_r;
  logic [48:0]        dlo_r, q_r;
  logic [5:0]         bit_cnt_r;
  logic               neg_r;
  logic signed [49:0] hx_r, hy_r;
  logic signed [31:0] res_x_r, res_y_r, res_z_r;
  logic               res_ok_r;
  logic               out_valid_r;
  logic signed [31:0] out_x_r, out_y_r, out_z_r;
  logic               out_ok_r;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] acc_sum, p_sel, w_val, base, sc_sum;
  logic [63:0]        a_mag, b_mag;
  logic [DW-1:0]      dfull;
  logic [64:0]        r2;
  logic               ge;
  logic [48:0]        magc;
  logic signed [49:0] n_val, h_val, h_sel;
  logic signed [42:0] hc;
  logic [14:0]        w_sel;
  logic               load_out;

  assign q_deq     = (state_r == ST_IDLE) && !q_empty;
  assign out_empty = !out_valid_r;
  assign out_win_x = out_x_r;
  assign out_win_y = out_y_r;
  assign out_win_z = out_z_r;
  assign out_ok    = out_ok_r;
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || out_pop);

  // Shared multiplier operand selection: matrix products, then viewport scaling.
  always_comb begin
    w_sel = d_r[0] ? cfg.view_height : cfg.view_width;
    h_sel = d_r[0] ? hy_r : hx_r;
    if (h_sel > 50'(HLIM)) begin
      hc = HLIM;
    end else if (h_sel < -50'(HLIM)) begin
      hc = -HLIM;
    end else begin
      hc = h_sel[42:0];
    end
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MUL: begin
        mul_a = m_r[{row_r, col_r}];
        case (col_r)
          2'd0:    mul_b = vx_r;
          2'd1:    mul_b = vy_r;
          default: mul_b = vz_r;
        endcase
      end
      ST_SC_LO: begin
        mul_a = {17'b0, w_sel};
        mul_b = {11'b0, hc[20:0]};
      end
      ST_SC_HI: begin
        mul_a = {17'b0, w_sel};
        mul_b = 32'($signed(hc[42:21]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Datapath helpers for accumulation, division and scaling.
  always_comb begin
    acc_sum = acc_r + (prod_r >>> FRAC_BITS);
    p_sel   = p_r[d_r];
    w_val   = p_r[3];
    a_mag   = p_sel[63] ? 64'(-p_sel) : 64'(p_sel);
    b_mag   = w_val[63] ? 64'(-w_val) : 64'(w_val);
    dfull   = {a_mag, {FRAC_BITS{1'b0}}};
    r2      = {rem_r, dlo_r[48]};
    ge      = (r2 >= {1'b0, div_b_r});
    magc    = (q_r > CAP) ? CAP : q_r;
    n_val   = neg_r ? -$signed({1'b0, magc}) : $signed({1'b0, magc});
    h_val   = (n_val >>> 1) + HALF;
    base    = (d_r[0] ? 64'(cfg.view_y) : 64'(cfg.view_x)) <<< FRAC_BITS;
    sc_sum  = acc_r + (prod_r <<< 21);
  end

  // Control state and matrix storage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          m_r[r*4+c] <= (r == c) ? ONE : '0;
        end
      end
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            if (q_item.func == FUNC_LOAD) begin
              m_r[q_item.elem_index] <= q_item.elem_value;
            end else begin
              state_r <= ST_MUL;
            end
          end
        end
        ST_MUL:  state_r <= ST_ACC;
        ST_ACC: begin
          if (col_r == 2'd2 && row_r == 2'd3) begin
            state_r <= ST_DIV_INIT;
          end else begin
            state_r <= ST_MUL;
          end
        end
        ST_DIV_INIT: begin
          if (w_val == '0) begin
            state_r <= ST_DONE;
          end else if (64'(dfull[DW-1:49]) >= b_mag) begin
            state_r <= ST_DIV_END;
          end else begin
            state_r <= ST_DIV_RUN;
          end
        end
        ST_DIV_RUN: begin
          if (bit_cnt_r == '0) begin
            state_r <= ST_DIV_END;
          end
        end
        ST_DIV_END: state_r <= (d_r == 2'd2) ? ST_SC_LO : ST_DIV_INIT;
        ST_SC_LO:   state_r <= ST_SC_HI;
        ST_SC_HI:   state_r <= ST_SC_ACC;
        ST_SC_ACC:  state_r <= d_r[0] ? ST_DONE : ST_SC_LO;
        ST_DONE: begin
          if (load_out) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      ST_IDLE: begin
        vx_r  <= q_item.vx;
        vy_r  <= q_item.vy;
        vz_r  <= q_item.vz;
        acc_r <= 64'(m_r[3]);
        row_r <= 2'd0;
        col_r <= 2'd0;
      end
      ST_ACC: begin
        if (col_r == 2'd2) begin
          p_r[row_r] <= acc_sum;
          acc_r      <= 64'(m_r[{row_r + 2'd1, 2'd3}]);
          col_r      <= 2'd0;
          row_r      <= row_r + 2'd1;
          d_r        <= 2'd0;
        end else begin
          acc_r <= acc_sum;
          col_r <= col_r + 2'd1;
        end
      end
      ST_DIV_INIT: begin
        neg_r     <= p_sel[63] ^ w_val[63];
        div_b_r   <= b_mag;
        rem_r     <= 64'(dfull[DW-1:49]);
        dlo_r     <= dfull[48:0];
        bit_cnt_r <= 6'd48;
        q_r       <= (64'(dfull[DW-1:49]) >= b_mag) ? CAP : '0;
        res_x_r   <= '0;
        res_y_r   <= '0;
        res_z_r   <= '0;
        res_ok_r  <= 1'b0;
      end
      ST_DIV_RUN: begin
        rem_r     <= ge ? 64'(r2 - {1'b0, div_b_r}) : r2[63:0];
        q_r       <= {q_r[47:0], ge};
        dlo_r     <= {dlo_r[47:0], 1'b0};
        bit_cnt_r <= bit_cnt_r - 6'd1;
      end
      ST_DIV_END: begin
        case (d_r)
          2'd0:    hx_r <= h_val;
          2'd1:    hy_r <= h_val;
          default: res_z_r <= sat32(64'(h_val));
        endcase
        d_r <= (d_r == 2'd2) ? 2'd0 : d_r + 2'd1;
      end
      ST_SC_HI: acc_r <= base + prod_r;
      ST_SC_ACC: begin
        if (d_r[0]) begin
          res_y_r  <= sat32(sc_sum);
          res_ok_r <= 1'b1;
        end else begin
          res_x_r <= sat32(sc_sum);
          d_r     <= 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register toward the output port.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_x_r  <= res_x_r;
      out_y_r  <= res_y_r;
      out_z_r  <= res_z_r;
      out_ok_r <= res_ok_r;
    end
  end

  `VPW_ASSERT_IMP(a_rem_below_divisor, state_r == ST_DIV_RUN, rem_r < div_b_r, "remainder not below divisor")
  `VPW_ASSERT_NXT(a_div_ends, (state_r == ST_DIV_RUN) && (bit_cnt_r == '0), state_r == ST_DIV_END, "divider overran")
  `VPW_ASSERT_NXT(a_done_holds, (state_r == ST_DONE) && out_valid_r && !out_pop, state_r == ST_DONE, "result dropped")

endmodule

// ===== rtl/vertex_project_to_window.sv =====
`timescale 1ns / 1ps
// Projects object-space vertices to window coordinates through a stored 4x4
// transform in signed fixed point. A load word (func 0) rewrites one matrix
// entry and gives no result; a vertex word gives exactly one result: the twelve
// matrix products go through one shared 32x32 multiplier, then each of the three
// divides by w runs in a one-bit-per-cycle restoring divider (the dominant cost),
// and viewport scaling follows. A two-word queue takes new words while a vertex
// is in work, and a result register holds the finished result until it is popped.
module vertex_project_to_window #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_func,
  input  logic [3:0]         in_elem_index,
  input  logic signed [31:0] in_elem_value,
  input  logic signed [31:0] in_vx,
  input  logic signed [31:0] in_vy,
  input  logic signed [31:0] in_vz,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_win_x,
  output logic signed [31:0] out_win_y,
  output logic signed [31:0] out_win_z,
  output logic               out_ok,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import vpw_pkg::*;

  item_t     push_item, head_item;
  logic      q_empty, q_deq;
  view_cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  // Viewport registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.view_x      <= '0;
      cfg_r.view_y      <= '0;
      cfg_r.view_width  <= 15'd640;
      cfg_r.view_height <= 15'd480;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_VIEW_X:      cfg_r.view_x      <= cfg_data;
        REG_VIEW_Y:      cfg_r.view_y      <= cfg_data;
        REG_VIEW_WIDTH:  cfg_r.view_width  <= cfg_data[14:0];
        REG_VIEW_HEIGHT: cfg_r.view_height <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  assign push_item = '{func: in_func, elem_index: in_elem_index,
                       elem_value: in_elem_value, vx: in_vx, vy: in_vy, vz: in_vz};

  vpw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .full      (in_full),
    .push_item (push_item),
    .deq       (q_deq),
    .empty     (q_empty),
    .head_item (head_item)
  );

  vpw_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (head_item),
    .q_deq     (q_deq),
    .cfg       (cfg_r),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_win_x (out_win_x),
    .out_win_y (out_win_y),
    .out_win_z (out_win_z),
    .out_ok    (out_ok)
  );

endmodule
